/* src/ssst_pkg.sv */
// ----------------------------------------------------------------------------
// ssst_pkg
// shared types and constants for the sample set statistics block
// ----------------------------------------------------------------------------
package ssst_pkg;

    // default capacity of the sample store
    localparam int DEF_MAX_SAMPLES = 32;

    // sample width and root operand width
    localparam int DATA_W = 32;
    localparam int ROOT_IN_W = 64;
    localparam logic [ROOT_IN_W-1:0] ROOT_TOP_BIT = 64'h4000_0000_0000_0000;

    // operation codes
    localparam logic [1:0] FUNC_APPEND  = 2'd0;
    localparam logic [1:0] FUNC_REPLACE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_INDEX = 2'd2;
    localparam logic [1:0] STATUS_EMPTY = 2'd3;

    // input item
    typedef struct packed {
        logic [1:0]               func;
        logic [4:0]               entry_index;
        logic signed [DATA_W-1:0] sample_value;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [1:0]               status;
        logic [5:0]               sample_count;
        logic signed [DATA_W-1:0] minimum;
        logic signed [DATA_W-1:0] maximum;
        logic signed [DATA_W-1:0] mean;
        logic [DATA_W-1:0]        std_dev;
    } t_out_item;

    // status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

/* src/ssst_div.sv */
// ----------------------------------------------------------------------------
// ssst_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ssst_div import ssst_pkg::*; #(
    parameter int NUM_W = 76,
    parameter int DEN_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_unit_stat       o_stat,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // trial subtract of the shifted remainder
    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

endmodule

/* src/ssst_sqrt.sv */
// ----------------------------------------------------------------------------
// ssst_sqrt
// integer square root, two operand bits per cycle
// ----------------------------------------------------------------------------
module ssst_sqrt import ssst_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [ROOT_IN_W-1:0] i_value,
    output t_unit_stat           o_stat,
    output logic [DATA_W-1:0]    o_root
);

    logic [ROOT_IN_W-1:0] r_v;
    logic [ROOT_IN_W-1:0] r_res;
    logic [ROOT_IN_W-1:0] r_bit;
    logic                 r_busy;
    logic                 r_done;
    logic [ROOT_IN_W-1:0] sum;
    logic                 ge;

    assign sum = r_res + r_bit;
    assign ge  = r_v >= sum;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == ROOT_IN_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_res <= '0;
            r_bit <= ROOT_TOP_BIT;
        end else if (r_busy) begin
            r_v   <= ge ? r_v - sum : r_v;
            r_res <= ge ? (r_res >> 1) + r_bit : r_res >> 1;
            r_bit <= r_bit >> 2;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_res[DATA_W-1:0];

endmodule

/* src/sample_set_statistics_top.sv */
// ----------------------------------------------------------------------------
// sample_set_statistics_top
// sample set with min, max, mean and population deviation per operation
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid, o_in_stall, i_in_item) carries one operation:
//   append a sample, replace an entry, or clear the set. output channel
//   (o_out_valid, i_out_stall, o_out_item) returns one result per operation
//   with status, count, minimum, maximum, mean and deviation.
//   one operation is worked on at a time; o_in_stall is high while it runs.
//   an operation runs through a rescan of the stored samples, the shift-add
//   products, the bit-serial divider, used for the mean and for the
//   variance, and the iterative root, in that order; an operation that
//   leaves the set empty goes straight to the result. the stored samples
//   are rescanned from the sample memory, one read a cycle.
//   the result sits in an output register, so the next operation is taken
//   while the receiver stalls; a new result waits until that one moves.
//   a synchronous reset empties the set and drops any pending result;
//   the sample memory itself is not cleared.
// ----------------------------------------------------------------------------
module sample_set_statistics_top import ssst_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SW  = DATA_W + CW;
    localparam int S2W = 2 * DATA_W - 2 + CW;
    localparam int NW  = 2 * DATA_W + 2 * CW;
    localparam int DW  = 2 * CW;
    localparam int IW  = CW + 5;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_SCAN = 8'b0000_0010,
        ST_MULN = 8'b0000_0100,
        ST_MULS = 8'b0000_1000,
        ST_DIVM = 8'b0001_0000,
        ST_DIVV = 8'b0010_0000,
        ST_SQRT = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [1:0]               r_status, n_status;
    logic [DATA_W-1:0]        mem [MAX_SAMPLES];
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [CW-1:0]            r_idx;
    logic                     r_v1, r_v2, r_v3;
    logic signed [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0]        r_ax;
    logic [2*DATA_W-1:0]      r_sq;
    logic                     r_first;
    logic signed [DATA_W-1:0] r_mn, r_mx, r_mean;
    logic [DATA_W-1:0]        r_sd;
    logic signed [SW-1:0]     r_s1;
    logic [S2W-1:0]           r_s2;
    logic [NW-1:0]            r_acc, r_mcand;
    logic [SW-1:0]            r_mplier;
    logic [SW-1:0]            s1_abs;
    logic                     issue;
    logic                     scan_end;
    logic                     in_xfer;
    logic                     out_free;
    logic                     div_start;
    logic [NW-1:0]            div_num;
    logic [DW-1:0]            div_den;
    t_unit_stat               div_stat;
    logic [NW-1:0]            div_quo;
    logic [DW-1:0]            div_rem;
    logic                     sqrt_start;
    t_unit_stat               sqrt_stat;
    logic [DATA_W-1:0]        sqrt_root;
    logic [DATA_W-1:0]        mean_q;
    t_out_item                r_out;
    logic                     r_out_valid;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_abs     = r_s1[SW-1] ? SW'(-r_s1) : SW'(r_s1);
    assign issue      = (r_state == ST_SCAN) && (r_idx < r_count);
    assign scan_end   = (r_state == ST_SCAN) && !issue && !r_v1 && !r_v2 && !r_v3;
    assign mean_q     = div_quo[DATA_W-1:0];

    // operation decode and store update
    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = AW'(r_count);
        n_count  = r_count;
        n_status = STATUS_OK;
        case (i_in_item.func)
            FUNC_APPEND: begin
                if (r_count >= CW'(MAX_SAMPLES)) begin
                    n_status = STATUS_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            FUNC_REPLACE: begin
                if (IW'(i_in_item.entry_index) >= IW'(r_count)) begin
                    n_status = STATUS_INDEX;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(i_in_item.entry_index);
                end
            end
            FUNC_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        if (n_status == STATUS_OK && n_count == '0) begin
            n_status = STATUS_EMPTY;
        end
    end

    // arithmetic unit hand-offs
    always_comb begin
        div_start  = 1'b0;
        div_num    = NW'(s1_abs);
        div_den    = DW'(r_count);
        sqrt_start = 1'b0;
        if (r_state == ST_MULS && r_mplier == '0) begin
            div_start = 1'b1;
        end
        if (r_state == ST_DIVM && div_stat.done) begin
            div_start = 1'b1;
            div_num   = r_acc;
            div_den   = DW'(r_count) * DW'(r_count);
        end
        if (r_state == ST_DIVV && div_stat.done) begin
            sqrt_start = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (n_count == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: if (scan_end) n_state = ST_MULN;
            ST_MULN: if (r_mplier == '0) n_state = ST_MULS;
            ST_MULS: if (r_mplier == '0) n_state = ST_DIVM;
            ST_DIVM: if (div_stat.done) n_state = ST_DIVV;
            ST_DIVV: if (div_stat.done) n_state = ST_SQRT;
            ST_SQRT: if (sqrt_stat.done) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sample memory
    always_ff @(posedge i_clk) begin
        if (in_xfer && wr_en) begin
            mem[wr_addr] <= i_in_item.sample_value;
        end
        r_rd_data <= mem[r_idx[AW-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            if (in_xfer) begin
                r_count <= n_count;
                r_idx   <= '0;
            end else if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan, accumulate and result datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_status <= n_status;
            r_first  <= 1'b1;
            r_mn     <= '0;
            r_mx     <= '0;
            r_mean   <= '0;
            r_sd     <= '0;
            r_s1     <= '0;
            r_s2     <= '0;
        end
        // stage one: min, max, sum and magnitude
        if (r_v1) begin
            r_first <= 1'b0;
            if (r_first || r_rd_data < r_mn) r_mn <= r_rd_data;
            if (r_first || r_rd_data > r_mx) r_mx <= r_rd_data;
            r_s1 <= r_s1 + SW'(r_rd_data);
            r_ax <= r_rd_data[DATA_W-1] ? DATA_W'(~r_rd_data + 1'b1) : DATA_W'(r_rd_data);
        end
        // stage two: square
        if (r_v2) begin
            r_sq <= r_ax * r_ax;
        end
        // stage three: sum of squares
        if (r_v3) begin
            r_s2 <= r_s2 + S2W'(r_sq);
        end
        // shift-add for n * s2 - s1 * s1
        if (scan_end) begin
            r_acc    <= '0;
            r_mcand  <= NW'(r_s2);
            r_mplier <= SW'(r_count);
        end else if (r_state == ST_MULN) begin
            if (r_mplier == '0) begin
                r_mcand  <= NW'(s1_abs);
                r_mplier <= s1_abs;
            end else begin
                if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
            end
        end else if (r_state == ST_MULS && r_mplier != '0) begin
            if (r_mplier[0]) r_acc <= r_acc - r_mcand;
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
        // floored mean from the magnitude quotient
        if (r_state == ST_DIVM && div_stat.done) begin
            if (!r_s1[SW-1]) begin
                r_mean <= mean_q;
            end else if (div_rem != '0) begin
                r_mean <= ~mean_q;
            end else begin
                r_mean <= -mean_q;
            end
        end
        if (r_state == ST_SQRT && sqrt_stat.done) begin
            r_sd <= sqrt_root;
        end
        // output register load
        if (r_state == ST_DONE && out_free) begin
            r_out.status       <= r_status;
            r_out.sample_count <= 6'(r_count);
            r_out.minimum      <= r_mn;
            r_out.maximum      <= r_mx;
            r_out.mean         <= r_mean;
            r_out.std_dev      <= r_sd;
        end
    end

    ssst_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    ssst_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (div_quo[ROOT_IN_W-1:0]),
        .o_stat  (sqrt_stat),
        .o_root  (sqrt_root)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES))
        else $error("sample count above capacity");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside the done state");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_stat.busy && sqrt_stat.busy))
        else $error("divider and root unit busy together");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= r_count))
        else $error("scan index past sample count");
`endif

endmodule

/* test/sample_set_statistics_top_tb.sv */
// ----------------------------------------------------------------------------
// sample_set_statistics_top_tb
// checks the sample set statistics block against its own predictor
// ----------------------------------------------------------------------------
// operations are sent through the input channel, the predicted statistics
// for each accepted operation are queued in a scoreboard, and each result
// transfer is compared field by field. sender gaps and receiver stalls vary
// by phase.
// ----------------------------------------------------------------------------

module sample_set_statistics_top_tb import ssst_pkg::*; ();

    localparam int STALL_LIMIT = 20000;

    // operation code the block ignores
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // holds the predicted set and the queue of predicted statistics
    class stats_scoreboard;
        logic signed [31:0] held_samples[32];
        int unsigned        held_count;
        ssst_pkg::t_out_item pending_stats[$];
        int unsigned        mismatches;
        int unsigned        results_seen;

        function new();
            held_count = 0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        // floor square root of a 64 bit value
        function automatic logic [63:0] floor_root(logic [63:0] v);
            logic [63:0] lo_r;
            logic [63:0] hi_r;
            logic [63:0] mid_r;
            lo_r = 0;
            hi_r = 64'h1_0000_0000;
            while (hi_r - lo_r > 1) begin
                mid_r = (lo_r + hi_r) >> 1;
                if (mid_r * mid_r <= v)
                    lo_r = mid_r;
                else
                    hi_r = mid_r;
            end
            return lo_r;
        endfunction

        // apply one accepted operation and queue its statistics
        function void note_operation(ssst_pkg::t_in_item op);
            ssst_pkg::t_out_item r;
            logic signed [63:0]  total;
            logic [127:0]        sq_total;
            logic [127:0]        numer;
            logic [127:0]        abs_total;
            logic signed [63:0]  q;
            logic signed [63:0]  x;
            logic [63:0]         ax;
            logic [63:0]         root;
            r = '0;
            r.status = STATUS_OK;
            if (op.func == FUNC_APPEND) begin
                if (held_count >= 32)
                    r.status = STATUS_FULL;
                else begin
                    held_samples[held_count] = op.sample_value;
                    held_count++;
                end
            end else if (op.func == FUNC_REPLACE) begin
                if (op.entry_index >= held_count)
                    r.status = STATUS_INDEX;
                else
                    held_samples[op.entry_index] = op.sample_value;
            end else if (op.func == FUNC_CLEAR) begin
                held_count = 0;
            end
            if (r.status == STATUS_OK && held_count == 0)
                r.status = STATUS_EMPTY;
            r.sample_count = held_count[5:0];
            if (held_count > 0) begin
                total = 0;
                sq_total = 0;
                r.minimum = held_samples[0];
                r.maximum = held_samples[0];
                for (int i = 0; i < held_count; i++) begin
                    x = held_samples[i];
                    ax = (x < 0) ? -x : x;
                    if (held_samples[i] < r.minimum) r.minimum = held_samples[i];
                    if (held_samples[i] > r.maximum) r.maximum = held_samples[i];
                    total += x;
                    sq_total += 128'(ax) * 128'(ax);
                end
                q = total / $signed(64'(held_count));
                if (total % $signed(64'(held_count)) != 0 && total < 0)
                    q -= 1;
                r.mean = q[31:0];
                abs_total = (total < 0) ? 128'(-total) : 128'(total);
                numer = sq_total * held_count - abs_total * abs_total;
                numer = numer / (held_count * held_count);
                root = floor_root(numer[63:0]);
                r.std_dev = root[31:0];
            end
            pending_stats.push_back(r);
        endfunction

        // compare one result transfer with the oldest prediction
        function void check_result(ssst_pkg::t_out_item got);
            ssst_pkg::t_out_item want;
            results_seen++;
            if (pending_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer %p", got);
                return;
            end
            want = pending_stats.pop_front();
            if (got.status != want.status || got.sample_count != want.sample_count ||
                got.minimum != want.minimum || got.maximum != want.maximum ||
                got.mean != want.mean || got.std_dev != want.std_dev) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    stats_scoreboard stats_sb;
    int send_gap_pct;
    int recv_stall_pct;
    int idle_cycles;
    int ops_sent;

    sample_set_statistics_top u_top (.*);

    always #4 i_clk = ~i_clk;

    // receiver stalls and result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            stats_sb.check_result(o_out_item);
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // send one operation and wait for its transfer
    task automatic send_op(logic [1:0] func, logic [4:0] idx, logic [31:0] val);
        t_in_item op;
        op.func = func;
        op.entry_index = idx;
        op.sample_value = val;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= op;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        stats_sb.note_operation(op);
        ops_sent++;
    endtask

    // random sample, often at the extremes
    function automatic logic [31:0] pick_sample();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    // a fill-and-edit sequence with some noise
    task automatic run_random(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_op(FUNC_APPEND, 5'($urandom), pick_sample());
            else if (pick < 85)
                send_op(FUNC_REPLACE, 5'($urandom_range(stats_sb.held_count + 1)),
                        pick_sample());
            else if (pick < 93)
                send_op(FUNC_REPLACE, 5'($urandom), $urandom);
            else if (pick < 97)
                send_op(FUNC_CLEAR, 5'($urandom), $urandom);
            else
                send_op(FUNC_UNUSED, 5'($urandom), $urandom);
        end
    endtask

    initial begin
        stats_sb = new();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        ops_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty set cases, extremes, full set, unused code
        send_op(FUNC_REPLACE, 5'd0, 32'h1234);
        send_op(FUNC_CLEAR, 5'd31, 32'hffff_ffff);
        send_op(FUNC_APPEND, 5'd0, 32'h8000_0000);
        send_op(FUNC_APPEND, 5'd31, 32'h7fff_ffff);
        send_op(FUNC_REPLACE, 5'd1, 32'h8000_0000);
        send_op(FUNC_REPLACE, 5'd2, 32'h0);
        send_op(FUNC_UNUSED, 5'd31, 32'hffff_ffff);
        for (int i = 0; i < 31; i++)
            send_op(FUNC_APPEND, 5'(i), (i % 2) ? 32'h7fff_ffff : 32'h8000_0000);
        send_op(FUNC_REPLACE, 5'd31, 32'hffff_ffff);
        send_op(FUNC_CLEAR, 5'd0, 32'h0);

        // random phases with varied idling
        run_random(100);
        send_gap_pct = 85;
        run_random(100);
        send_gap_pct = 0;
        recv_stall_pct = 85;
        run_random(100);
        send_gap_pct = 20;
        recv_stall_pct = 20;
        run_random(100);
        i_in_valid <= 1'b0;
        recv_stall_pct = 0;

        while (stats_sb.pending_stats.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        $display("sent %0d operations, checked %0d results", ops_sent,
                 stats_sb.results_seen);
        $display("covered appends, replaces, clears, full and bad index cases");
        if (stats_sb.mismatches == 0 && stats_sb.pending_stats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
